// ===== hdl/iole_pkg.sv =====
`default_nettype none

package iole_pkg;

  // default sizes of the list
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed widths of the request and result fields
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_REMOVE     = 3'd5,
    CMD_FIND       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_REMOVE = 3'd2,
    CELL_MATCH  = 3'd3,
    CELL_SHIFT  = 3'd4
  } cell_op_e;

  // control group from the sequencer to the row of cells
  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/iole_cell.sv =====
`default_nettype none

module iole_cell
  import iole_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [CNT_W-1:0]      pos_i,
  input  wire logic [CNT_W-1:0]      count_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  input  wire logic                  right_hit_i,
  output logic      [DATA_WIDTH-1:0] entry_o,
  output logic                       hit_o,
  output logic      [DATA_WIDTH-1:0] tail_o
);

  localparam logic [CNT_W-1:0] MyIdx  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] MyNext = CNT_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  hit_q, hit_d;

  // next entry and match flag from the broadcast operation
  always_comb begin
    entry_d = entry_q;
    hit_d   = hit_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = left_i;
        end else if (MyIdx == pos_i) begin
          entry_d = word_i;
        end
      end
      CELL_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_i;
        end
      end
      CELL_MATCH: hit_d = (entry_q == word_i);
      CELL_SHIFT: hit_d = right_hit_i;
      default:    entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;
  // entry shows on the back bus only when this cell is the last one in use
  assign tail_o  = (MyNext == count_i) ? entry_q : '0;

endmodule

`default_nettype wire

// ===== hdl/iole_chain.sv =====
`default_nettype none

module iole_chain
  import iole_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned CNT_W      = 5
) (
  input  wire logic                  clk_i,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [CNT_W-1:0]      pos_i,
  input  wire logic [CNT_W-1:0]      count_i,
  input  wire logic [DATA_WIDTH-1:0] word_i,
  output logic      [DATA_WIDTH-1:0] front_o,
  output logic      [DATA_WIDTH-1:0] back_o,
  output logic                       hit0_o
);

  logic [DATA_WIDTH-1:0] entry [CAPACITY];
  logic [DATA_WIDTH-1:0] tail  [CAPACITY];
  logic                  hit   [CAPACITY];

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    logic                  right_hit_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w     = '0;
      assign right_hit_w = 1'b0;
    end else begin : g_mid_r
      assign right_w     = entry[i+1];
      assign right_hit_w = hit[i+1];
    end

    iole_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .pos_i       (pos_i),
      .count_i     (count_i),
      .word_i      (word_i),
      .left_i      (left_w),
      .right_i     (right_w),
      .right_hit_i (right_hit_w),
      .entry_o     (entry[i]),
      .hit_o       (hit[i]),
      .tail_o      (tail[i])
    );
  end

  // at most one cell drives the back bus, so an or-merge selects it
  always_comb begin
    back_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_o = back_o | tail[i];
    end
  end

  assign front_o = entry[0];
  assign hit0_o  = hit[0];

endmodule

`default_nettype wire

// ===== hdl/indexed_ordered_list_engine_core.sv =====
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------------
// request  | in        | in_valid_i / in_ready_o | cmd_i, position_i, value_i
// result   | out       | out_valid_o / out_ready_i | status_o, found_o, found_index_o,
//          |           |                        | front_value_o, back_value_o, item_count_o,
//          |           |                        | is_empty_o
//
// One request at a time. Every command but find goes from acceptance straight to the
// result state: the cells update at the accepting edge, the result registers at the next.
// Find scans first and reports the first hit by index, or the count on a miss: match
// flags are captured in all cells at the accepting edge, then shifted toward cell 0 one
// place a cycle. No new request is taken until the result of the last one is registered.
// rst_ni clears the count and the control; stored entries are not cleared.
// A held result blocks the next request only until it is taken.
`default_nettype none

module indexed_ordered_list_engine_core
  import iole_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [CMD_W-1:0]          cmd_i,
  input  wire logic [CNT_W-1:0]          position_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [STATUS_W-1:0]       status_o,
  output logic                           found_o,
  output logic      [CNT_W-1:0]          found_index_o,
  output logic signed [VALUE_W-1:0]      front_value_o,
  output logic signed [VALUE_W-1:0]      back_value_o,
  output logic      [CNT_W-1:0]          item_count_o,
  output logic                           is_empty_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  localparam logic [CNT_W-1:0] Full = CNT_W'(CAPACITY);

  state_e                state_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q;
  status_e               stat_q, stat_d;
  logic                  found_q;
  logic [CNT_W-1:0]      fidx_q;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_found_q;
  logic [CNT_W-1:0]      out_fidx_q;
  logic [VALUE_W-1:0]    out_front_q, out_back_q;
  logic [CNT_W-1:0]      out_count_q;

  logic                  accept;
  cmd_e                  cmd;
  cell_ctrl_t            ctrl;
  logic [CNT_W-1:0]      cell_pos;
  logic [CNT_W-1:0]      ins_pos;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] front, back;
  logic                  hit0;
  logic                  is_find;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(cmd_i);
  assign word       = DATA_WIDTH'($unsigned(value_i));
  assign is_find    = (cmd == CMD_FIND);

  // insert slot: front, back, or the requested position clamped to the count
  always_comb begin
    case (cmd)
      CMD_PUSH_FRONT: ins_pos = '0;
      CMD_PUSH_BACK:  ins_pos = count_q;
      default:        ins_pos = (position_i > count_q) ? count_q : position_i;
    endcase
  end

  // request decode into a cell operation, new count and status; a shift while scanning
  always_comb begin
    ctrl.op  = CELL_HOLD;
    cell_pos = '0;
    count_d  = count_q;
    stat_d   = STAT_OK;
    if (state_q == S_SCAN) begin
      ctrl.op = CELL_SHIFT;
    end else if (accept) begin
      unique case (cmd) inside
        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
          if (count_q == Full) begin
            stat_d = STAT_FULL;
          end else begin
            ctrl.op  = CELL_INSERT;
            cell_pos = ins_pos;
            count_d  = count_q + CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (count_q == '0) begin
            stat_d = STAT_EMPTY;
          end else begin
            ctrl.op = CELL_REMOVE;
            count_d = count_q - CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (count_q == '0) begin
            stat_d = STAT_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (position_i >= count_q) begin
            stat_d = STAT_RANGE;
          end else begin
            ctrl.op  = CELL_REMOVE;
            cell_pos = position_i;
            count_d  = count_q - CNT_W'(1);
          end
        end
        CMD_FIND:  ctrl.op = CELL_MATCH;
        CMD_CLEAR: count_d = '0;
        default:   count_d = count_q;
      endcase
    end
  end

  iole_chain #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .pos_i   (cell_pos),
    .count_i (count_q),
    .word_i  (word),
    .front_o (front),
    .back_o  (back),
    .hit0_o  (hit0)
  );

  // sequencer, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      stat_q       <= STAT_OK;
      found_q      <= 1'b0;
      fidx_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_found_q  <= 1'b0;
      out_fidx_q   <= '0;
      out_front_q  <= '0;
      out_back_q   <= '0;
      out_count_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q <= count_d;
            stat_q  <= stat_d;
            found_q <= 1'b0;
            fidx_q  <= '0;
            idx_q   <= '0;
            state_q <= is_find ? S_SCAN : S_RESP;
          end
        end
        S_SCAN: begin
          if (idx_q == count_q) begin
            found_q <= 1'b0;
            fidx_q  <= count_q;
            state_q <= S_RESP;
          end else if (hit0) begin
            found_q <= 1'b1;
            fidx_q  <= idx_q;
            state_q <= S_RESP;
          end else begin
            idx_q <= idx_q + CNT_W'(1);
          end
        end
        S_RESP: begin
          out_valid_q  <= 1'b1;
          out_status_q <= stat_q;
          out_found_q  <= found_q;
          out_fidx_q   <= fidx_q;
          out_front_q  <= (count_q != '0) ? VALUE_W'(front) : '0;
          out_back_q   <= VALUE_W'(back);
          out_count_q  <= count_q;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign found_index_o = out_fidx_q;
  assign front_value_o = $signed(out_front_q);
  assign back_value_o  = $signed(out_back_q);
  assign item_count_o  = out_count_q;
  assign is_empty_o    = (out_count_q == '0);

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while another is in progress");

  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (found_index_o < item_count_o))
    else $error("found index outside the list");

  a_miss_is_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && idx_q == count_q) |=> (fidx_q == count_q && !found_q))
    else $error("missed find does not report the count");

endmodule

`default_nettype wire

// ===== dv/iole_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iole_checker
  import iole_pkg::*;
#(
  parameter int unsigned CNT_W = $clog2(CAPACITY_DEF + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      req_valid_i,
  input  wire logic                      req_ready_i,
  input  wire logic [CMD_W-1:0]          cmd_i,
  input  wire logic [CNT_W-1:0]          position_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  input  wire logic                      res_valid_i,
  input  wire logic                      res_ready_i,
  input  wire logic [STATUS_W-1:0]       status_i,
  input  wire logic                      found_i,
  input  wire logic [CNT_W-1:0]          found_index_i,
  input  wire logic signed [VALUE_W-1:0] front_value_i,
  input  wire logic signed [VALUE_W-1:0] back_value_i,
  input  wire logic [CNT_W-1:0]          item_count_i,
  input  wire logic                      is_empty_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);

  // list state after a request, as the block reports it
  typedef struct packed {
    status_e            status;
    logic               found;
    logic [CNT_W-1:0]   found_index;
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic [CNT_W-1:0]   item_count;
    logic               is_empty;
  } list_result_t;

  // shadow copy of the stored list
  logic [VALUE_W-1:0] list_words [CAPACITY_DEF];
  int unsigned        list_len;

  list_result_t expected_results [$];
  int unsigned  mismatches;

  assign fail_count_o = mismatches;

  // close the gap left by the entry at index at
  function automatic void drop_word(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  // apply one request to the shadow list and build the expected result
  function automatic list_result_t apply_list_cmd(cmd_e op, logic [CNT_W-1:0] pos,
                                                  logic [VALUE_W-1:0] word);
    list_result_t r;
    int unsigned  at;
    int unsigned  i;
    r = '0;
    r.status = STAT_OK;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (list_len >= CAPACITY_DEF) begin
          r.status = STAT_FULL;
        end else begin
          if (op == CMD_PUSH_FRONT) at = 0;
          else if (op == CMD_PUSH_BACK) at = list_len;
          else at = pos;
          // insert past the end appends
          if (at > list_len) at = list_len;
          for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
          list_words[at] = word;
          list_len++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else drop_word((op == CMD_POP_FRONT) ? 0 : list_len - 1);
      end
      CMD_REMOVE: begin
        if (pos >= list_len) r.status = STAT_RANGE;
        else drop_word(pos);
      end
      CMD_FIND: begin
        // first match wins, a miss reports the count
        r.found_index = CNT_W'(list_len);
        for (i = 0; i < list_len; i++) begin
          if (!r.found && list_words[i] == word) begin
            r.found       = 1'b1;
            r.found_index = CNT_W'(i);
          end
        end
      end
      default: list_len = 0;
    endcase
    r.item_count = CNT_W'(list_len);
    r.is_empty   = (list_len == 0);
    if (list_len != 0) begin
      r.front_value = list_words[0];
      r.back_value  = list_words[list_len - 1];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // results are retired before the request of the same edge is predicted
  always @(posedge clk_i) begin : track
    list_result_t want;
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                   $time, status_i, item_count_i);
          mismatches++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("status", want.status, status_i);
          check_field("found", want.found, found_i);
          check_field("found_index", want.found_index, found_index_i);
          check_field("front_value", want.front_value, front_value_i);
          check_field("back_value", want.back_value, back_value_i);
          check_field("item_count", want.item_count, item_count_i);
          check_field("is_empty", want.is_empty, is_empty_i);
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_results.insert(expected_results.size(),
                                apply_list_cmd(cmd_e'(cmd_i), position_i, value_i));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb
  import iole_pkg::*;
;

  localparam int unsigned CNT_W = $clog2(CAPACITY_DEF + 1);

  // mixes of commands in the random part
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;

  localparam int IDLE_HEAVY = 87;
  localparam int IDLE_LIGHT = 12;
  localparam int PHASE_REQS = 350;
  localparam int HOLD_CYCLES = 60;

  logic                      clk;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready;
  logic [CMD_W-1:0]          cmd;
  logic [CNT_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       status;
  logic                      found;
  logic [CNT_W-1:0]          found_index;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [CNT_W-1:0]          item_count;
  logic                      is_empty;
  int unsigned               fail_count;
  int unsigned               pending;

  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  indexed_ordered_list_engine_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .position_i    (position),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .found_o       (found),
    .found_index_o (found_index),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .item_count_o  (item_count),
    .is_empty_o    (is_empty)
  );

  iole_checker #(.CNT_W(CNT_W)) chk (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid),
    .req_ready_i   (in_ready),
    .cmd_i         (cmd),
    .position_i    (position),
    .value_i       (value),
    .res_valid_i   (out_valid),
    .res_ready_i   (out_ready),
    .status_i      (status),
    .found_i       (found),
    .found_index_i (found_index),
    .front_value_i (front_value),
    .back_value_i  (back_value),
    .item_count_i  (item_count),
    .is_empty_i    (is_empty),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on demand
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_req(cmd_e op, logic [CNT_W-1:0] pos, logic [VALUE_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    position <= pos;
    value    <= word;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic cmd_e choose_cmd(int mode);
    int w [8];
    int roll;
    int k;
    // weights in command code order
    case (mode)
      MODE_GROW:   w = '{28, 28, 4, 3, 24, 2, 10, 1};
      MODE_SHRINK: w = '{5, 5, 20, 20, 5, 34, 10, 1};
      default:     w = '{14, 14, 10, 10, 16, 14, 18, 4};
    endcase
    roll = $urandom_range(0, 99);
    for (k = 0; k < 8; k++) begin
      if (roll < w[k]) return cmd_e'(k);
      roll -= w[k];
    end
    return CMD_CLEAR;
  endfunction

  // mostly in-range positions, small ones often so removes land
  function automatic logic [CNT_W-1:0] pick_position();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return CNT_W'($urandom_range(0, 31));
    if (roll < 6) return CNT_W'($urandom_range(0, CAPACITY_DEF));
    return CNT_W'($urandom_range(0, 4));
  endfunction

  // a small pool of words gives duplicates and find hits
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 1)) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'h0000_0001;
      5:       return 32'h5555_5555;
      6:       return 32'haaaa_aaaa;
      default: return 32'h0000_002a;
    endcase
  endfunction

  initial begin : stimulus
    int ph;
    int n;
    int mode;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    cmd            = '0;
    position       = '0;
    value          = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // empty list corner cases
    send_req(CMD_POP_FRONT, '0, '0);
    send_req(CMD_POP_BACK, '0, '0);
    send_req(CMD_REMOVE, '0, '0);
    send_req(CMD_FIND, '0, '0);
    // insert past the end, extremes of the data word
    send_req(CMD_INSERT, 5'd31, 32'h8000_0000);
    send_req(CMD_PUSH_FRONT, '0, 32'h7fff_ffff);
    send_req(CMD_PUSH_BACK, 5'd16, 32'hffff_ffff);
    send_req(CMD_INSERT, 5'd1, 32'h0000_0000);
    send_req(CMD_FIND, '0, 32'h0000_0000);
    send_req(CMD_FIND, '0, 32'h1234_5678);
    send_req(CMD_REMOVE, 5'd16, '0);
    send_req(CMD_REMOVE, 5'd1, '0);
    // fill to capacity with repeated words, then hit the full list
    for (n = 0; n < 13; n++) send_req(CMD_PUSH_BACK, '0, VALUE_W'(n % 4));
    send_req(CMD_PUSH_FRONT, '0, 32'h0000_0005);
    send_req(CMD_INSERT, 5'd3, 32'h0000_0005);
    send_req(CMD_CLEAR, '0, '0);

    // random part: no idling, idle sender, stalling receiver, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;          recv_stall_pct = 0;          end
        1:       begin send_idle_pct = IDLE_HEAVY; recv_stall_pct = 0;          end
        2:       begin send_idle_pct = 0;          recv_stall_pct = IDLE_HEAVY; end
        default: begin send_idle_pct = IDLE_LIGHT; recv_stall_pct = IDLE_LIGHT; end
      endcase
      mode = MODE_MIXED;
      for (n = 0; n < PHASE_REQS; n++) begin
        if (n % 40 == 0) mode = $urandom_range(MODE_GROW, MODE_MIXED);
        if (n == 100) hold_req = 1'b1;
        // drain before going on
        if (n == 200) begin
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        send_req(choose_cmd(mode), pick_position(), pick_value());
      end
    end

    in_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== indexed_ordered_list_engine_core.f =====
hdl/iole_pkg.sv
hdl/iole_cell.sv
hdl/iole_chain.sv
hdl/indexed_ordered_list_engine_core.sv
dv/iole_checker.sv
dv/tb.sv
